[hw/rtl/two_peak_threshold_binarizer_top_defines.svh]
// assertion macros for the two-peak threshold binarizer checker
// expects signals named clock and reset in the scope of each use
`ifndef TWO_PEAK_THRESHOLD_BINARIZER_TOP_DEFINES_SVH
`define TWO_PEAK_THRESHOLD_BINARIZER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define TPTB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define TPTB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/tptb_pkg.sv]
// shared types, constants and helpers for the two-peak threshold binarizer
// no dependencies
package tptb_pkg;

   localparam int GREY_LEVELS    = 256;
   localparam int BIN_ADDR_W     = $clog2(GREY_LEVELS);
   localparam int BIN_W          = 12;
   localparam int PIXEL_W        = 8;
   localparam int ROW_W          = 9;
   localparam int COL_W          = 10;
   localparam int ACC_W          = ROW_W + 3;
   localparam int SAMPLE_ROWS    = 7;
   localparam int DIST_W         = 8;
   localparam int SQ_W           = 2 * DIST_W;
   localparam int SCORE_W        = BIN_W + SQ_W;

   localparam int DEF_MAX_WIDTH  = 640;
   localparam int DEF_MAX_HEIGHT = 480;

   localparam logic [BIN_W-1:0]   BIN_MAX      = '1;
   localparam logic [PIXEL_W-1:0] PIXEL_WHITE  = '1;
   localparam logic [PIXEL_W-1:0] PIXEL_BLACK  = '0;
   localparam logic [ROW_W-1:0]   RESET_HEIGHT = 9'd120;
   localparam logic [COL_W-1:0]   RESET_WIDTH  = 10'd160;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = COL_W;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b1;

   // phase codes
   localparam logic PHASE_GATHER   = 1'b0;
   localparam logic PHASE_BINARIZE = 1'b1;

   // reciprocal of 5 in q14, exact for numerators below 2048
   localparam int RECIP5_SHIFT = 14;
   localparam logic [11:0] RECIP5 = 12'd3277;

   typedef struct packed {
      logic [COL_W-1:0] lo;
      logic [COL_W-1:0] hi;
   } geom_type;

   // sampled column window [w/2 - 2w/5, w/2 + 2w/5)
   function automatic geom_type column_window(input logic [COL_W-1:0] w);
      logic [COL_W-2:0] half;
      logic [22:0]      scaled;
      logic [COL_W-2:0] span;
      geom_type         g;
      half   = w[COL_W-1:1];
      scaled = {12'b0, w, 1'b0} * {11'b0, RECIP5};
      span   = scaled[RECIP5_SHIFT +: (COL_W-1)];
      g.lo   = {1'b0, half - span};
      g.hi   = {1'b0, half} + {1'b0, span};
      return g;
   endfunction

endpackage

[hw/rtl/tptb_if.sv]
// valid/ready channel interfaces for pixel requests and binarized responses
// depends on tptb_pkg
interface tptb_req_if import tptb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   logic [ROW_W-1:0]   row;
   logic [COL_W-1:0]   column;
   logic               phase;

   modport source (output valid, pixel, row, column, phase, input ready);
   modport sink   (input valid, pixel, row, column, phase, output ready);
endinterface

interface tptb_rsp_if import tptb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] binary_pixel;
   logic [PIXEL_W-1:0] threshold;
   logic               last;

   modport source (output valid, binary_pixel, threshold, last, input ready);
   modport sink   (input valid, binary_pixel, threshold, last, output ready);
endinterface

[hw/rtl/two_peak_threshold_binarizer_top.sv]
// two-peak histogram threshold binarizer, top level
// depends on tptb_pkg and the channel interfaces in tptb_if.sv
//
// Usage:
// req_stream carries pixel beats tagged with row, column and phase. phase 0
// beats gather a 256-bin histogram from seven sample rows over the middle
// columns; phase 1 beats are binarized against the current threshold and
// return one rsp_stream beat each (binary_pixel, threshold, last).
// A binarize beat lands in the output register in the cycle after acceptance;
// it stays idle, so binarize runs one beat a cycle while rsp_stream is ready.
// A gather beat steps through accept, 7 sample-row compares through one
// shared adder, then a read-modify-write of the histogram memory.
// The gather beat at the last row and column adds the threshold walk:
// a read and a compare per bin for the main peak, then a read, square, score
// and compare per bin for the second peak (the single multiplier is used
// twice per bin); S_DONE sets the threshold and clears all bin valid bits.
// Reset (synchronous, active high) restores 120 x 160, threshold 0 and
// clears all bin valid bits at once; there is no memory clearing pass.
// While rsp_stream stalls, the held beat stays put and req_stream accepts
// nothing until the output register drains. csr_we writes image_height
// (index 0, low 9 data bits, saturated) or image_width (index 1), saturated.
module two_peak_threshold_binarizer_top
   import tptb_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   tptb_req_if.sink              req_stream,
   tptb_rsp_if.source            rsp_stream,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [ROW_W-1:0] HEIGHT_CAP =
      (MAX_HEIGHT > 511) ? 9'd511 : ROW_W'(MAX_HEIGHT);
   localparam logic [COL_W-1:0] WIDTH_CAP =
      (MAX_WIDTH > 1023) ? 10'd1023 : COL_W'(MAX_WIDTH);
   localparam logic [BIN_ADDR_W-1:0] LAST_BIN = BIN_ADDR_W'(GREY_LEVELS - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_ROWS, S_UPD, S_P1_RD, S_P1_CMP,
      S_P2_RD, S_P2_SQ, S_P2_SC, S_P2_CMP, S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [ROW_W-1:0]      height_ff, height_in;
   logic [COL_W-1:0]      width_ff, width_in;
   geom_type              geom_ff, geom_in;

   logic [PIXEL_W-1:0]    pix_ff, pix_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic                  last_hit_ff, last_hit_in;
   logic                  col_ok_ff, col_ok_in;
   logic [2:0]            k_ff, k_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [2:0]            hits_ff, hits_in;

   logic [BIN_ADDR_W-1:0] idx_ff, idx_in;
   logic [BIN_W-1:0]      best_ff, best_in;
   logic [BIN_ADDR_W-1:0] p1_ff, p1_in;
   logic [BIN_ADDR_W-1:0] p2_ff, p2_in;
   logic [SCORE_W-1:0]    score_ff, score_in;
   logic [DIST_W-1:0]     d_ff, d_in;
   logic [BIN_W-1:0]      cnt_ff, cnt_in;
   logic [SCORE_W-1:0]    prod_ff, prod_in;
   logic [PIXEL_W-1:0]    thr_ff, thr_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]    rsp_bin_ff, rsp_bin_in;
   logic [PIXEL_W-1:0]    rsp_thr_ff, rsp_thr_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [GREY_LEVELS-1:0] valid_ff, valid_in;
   logic                   rd_valid_ff, rd_valid_in;

   // histogram memory
   logic [BIN_W-1:0]      hist_mem [GREY_LEVELS];
   logic [BIN_W-1:0]      rd_data_ff;
   logic                  rd_en;
   logic [BIN_ADDR_W-1:0] rd_addr;
   logic                  wr_en;
   logic [BIN_ADDR_W-1:0] wr_addr;
   logic [BIN_W-1:0]      wr_data;

   // shared multiplier
   logic [BIN_W-1:0]      mul_a;
   logic [SQ_W-1:0]       mul_b;
   logic [SCORE_W-1:0]    mul_p;

   logic                  req_fire;
   logic [BIN_W-1:0]      bin_val;
   logic [ACC_W-1:0]      acc_next;
   logic [BIN_W:0]        bin_sum;
   logic [BIN_ADDR_W:0]   peak_sum;
   logic [ROW_W-1:0]      height_wr;
   logic [COL_W-1:0]      width_wr;

   function automatic logic at_last(input logic [ROW_W-1:0] h, input logic [COL_W-1:0] w,
                                    input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
      return (h != '0) && (w != '0) && (r == h - 9'd1) && (c == w - 10'd1);
   endfunction

   assign req_stream.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_stream.ready);
   assign req_fire         = req_stream.valid && req_stream.ready;

   assign rsp_stream.valid        = rsp_valid_ff;
   assign rsp_stream.binary_pixel = rsp_bin_ff;
   assign rsp_stream.threshold    = rsp_thr_ff;
   assign rsp_stream.last         = rsp_last_ff;

   // a bin never written since the last clear reads as zero
   assign bin_val  = rd_valid_ff ? rd_data_ff : '0;
   assign acc_next = acc_ff + {3'b0, height_ff};
   assign bin_sum  = {1'b0, bin_val} + {{(BIN_W-2){1'b0}}, hits_ff};
   assign peak_sum = {1'b0, p1_ff} + {1'b0, p2_ff};

   assign mul_a = (state_ff == S_P2_SQ) ? {{(BIN_W-DIST_W){1'b0}}, d_ff} : cnt_ff;
   assign mul_b = (state_ff == S_P2_SQ) ? {{(SQ_W-DIST_W){1'b0}}, d_ff} : prod_ff[SQ_W-1:0];
   assign mul_p = {{SQ_W{1'b0}}, mul_a} * {{BIN_W{1'b0}}, mul_b};

   assign height_wr = (csr_data[ROW_W-1:0] > HEIGHT_CAP) ? HEIGHT_CAP : csr_data[ROW_W-1:0];
   assign width_wr  = (csr_data > WIDTH_CAP) ? WIDTH_CAP : csr_data;

   always_comb begin
      state_in     = state_ff;
      height_in    = height_ff;
      width_in     = width_ff;
      geom_in      = geom_ff;
      pix_in       = pix_ff;
      row_in       = row_ff;
      last_hit_in  = last_hit_ff;
      col_ok_in    = col_ok_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      hits_in      = hits_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      score_in     = score_ff;
      d_in         = d_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      thr_in       = thr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_stream.ready;
      rsp_bin_in   = rsp_bin_ff;
      rsp_thr_in   = rsp_thr_ff;
      rsp_last_in  = rsp_last_ff;
      valid_in     = valid_ff;
      rd_valid_in  = rd_valid_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = pix_ff;
      wr_data      = (bin_sum > {1'b0, BIN_MAX}) ? BIN_MAX : bin_sum[BIN_W-1:0];

      if (csr_we) begin
         case (csr_index)
            REG_IMAGE_HEIGHT: height_in = height_wr;
            REG_IMAGE_WIDTH: begin
               width_in = width_wr;
               geom_in  = column_window(width_wr);
            end
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_stream.phase == PHASE_BINARIZE) begin
                  rsp_valid_in = 1'b1;
                  rsp_bin_in   = (req_stream.pixel >= thr_ff) ? PIXEL_WHITE : PIXEL_BLACK;
                  rsp_thr_in   = thr_ff;
                  rsp_last_in  = at_last(height_ff, width_ff, req_stream.row,
                                         req_stream.column);
               end else begin
                  pix_in      = req_stream.pixel;
                  row_in      = req_stream.row;
                  last_hit_in = at_last(height_ff, width_ff, req_stream.row,
                                        req_stream.column);
                  col_ok_in   = (req_stream.column >= geom_ff.lo) &&
                                (req_stream.column < geom_ff.hi);
                  k_in        = 3'd1;
                  acc_in      = '0;
                  hits_in     = '0;
                  rd_en       = 1'b1;
                  rd_addr     = req_stream.pixel;
                  state_in    = S_ROWS;
               end
            end
         end
         S_ROWS: begin
            // running k*height through one adder, sample row is acc/8
            acc_in = acc_next;
            if (acc_next[ACC_W-1:3] == row_ff) begin
               hits_in = hits_ff + 3'd1;
            end
            if (k_ff == 3'(SAMPLE_ROWS)) begin
               state_in = S_UPD;
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         S_UPD: begin
            if (col_ok_ff && (hits_ff != '0)) begin
               wr_en             = 1'b1;
               valid_in[pix_ff]  = 1'b1;
            end
            idx_in   = '0;
            state_in = last_hit_ff ? S_P1_RD : S_IDLE;
         end
         S_P1_RD: begin
            rd_en    = 1'b1;
            state_in = S_P1_CMP;
         end
         S_P1_CMP: begin
            if ((idx_ff == '0) || (bin_val > best_ff)) begin
               best_in = bin_val;
               p1_in   = idx_ff;
            end
            if (idx_ff == LAST_BIN) begin
               idx_in   = '0;
               state_in = S_P2_RD;
            end else begin
               idx_in   = idx_ff + BIN_ADDR_W'(1);
               state_in = S_P1_RD;
            end
         end
         S_P2_RD: begin
            rd_en    = 1'b1;
            d_in     = (idx_ff > p1_ff) ? (idx_ff - p1_ff) : (p1_ff - idx_ff);
            state_in = S_P2_SQ;
         end
         S_P2_SQ: begin
            prod_in  = mul_p;
            cnt_in   = bin_val;
            state_in = S_P2_SC;
         end
         S_P2_SC: begin
            prod_in  = mul_p;
            state_in = S_P2_CMP;
         end
         S_P2_CMP: begin
            if ((idx_ff == '0) || (prod_ff > score_ff)) begin
               score_in = prod_ff;
               p2_in    = idx_ff;
            end
            if (idx_ff == LAST_BIN) begin
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff + BIN_ADDR_W'(1);
               state_in = S_P2_RD;
            end
         end
         S_DONE: begin
            thr_in   = peak_sum[BIN_ADDR_W:1];
            valid_in = '0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (rd_en) begin
         rd_valid_in = valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         height_ff    <= RESET_HEIGHT;
         width_ff     <= RESET_WIDTH;
         geom_ff      <= column_window(RESET_WIDTH);
         thr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         height_ff    <= height_in;
         width_ff     <= width_in;
         geom_ff      <= geom_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
      pix_ff      <= pix_in;
      row_ff      <= row_in;
      last_hit_ff <= last_hit_in;
      col_ok_ff   <= col_ok_in;
      k_ff        <= k_in;
      acc_ff      <= acc_in;
      hits_ff     <= hits_in;
      idx_ff      <= idx_in;
      best_ff     <= best_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      score_ff    <= score_in;
      d_ff        <= d_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      rsp_bin_ff  <= rsp_bin_in;
      rsp_thr_ff  <= rsp_thr_in;
      rsp_last_ff <= rsp_last_in;
      rd_valid_ff <= rd_valid_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
   end

endmodule

[hw/rtl/tptb_checker.sv]
// port-level checks for the two-peak threshold binarizer, bound to the top
// depends on two_peak_threshold_binarizer_top_defines.svh and tptb_pkg
`include "two_peak_threshold_binarizer_top_defines.svh"

module tptb_checker
   import tptb_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_phase,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [PIXEL_W-1:0] rsp_binary_pixel,
   input logic [PIXEL_W-1:0] rsp_threshold,
   input logic               rsp_last
);

   // a stalled response beat stays offered
   `TPTB_ASSERT_NEXT(a_rsp_valid_holds, rsp_valid && !rsp_ready, rsp_valid, "rsp valid dropped")

   // and keeps its payload
   `TPTB_ASSERT_NEXT(a_rsp_payload_holds, rsp_valid && !rsp_ready, $stable(rsp_binary_pixel) && $stable(rsp_threshold) && $stable(rsp_last), "rsp payload changed under stall")

   // binarized output is black or white only
   `TPTB_ASSERT_NOW(a_binary_levels, rsp_valid, (rsp_binary_pixel == PIXEL_BLACK) || (rsp_binary_pixel == PIXEL_WHITE), "binary pixel not 0 or 255")

   // a gather beat keeps the block busy with the sample-row walk
   `TPTB_ASSERT_NEXT(a_gather_busy, req_valid && req_ready && (req_phase == PHASE_GATHER), !req_ready, "ready right after gather beat")

endmodule

bind two_peak_threshold_binarizer_top tptb_checker u_tptb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_stream.valid),
   .req_ready        (req_stream.ready),
   .req_phase        (req_stream.phase),
   .rsp_valid        (rsp_stream.valid),
   .rsp_ready        (rsp_stream.ready),
   .rsp_binary_pixel (rsp_stream.binary_pixel),
   .rsp_threshold    (rsp_stream.threshold),
   .rsp_last         (rsp_stream.last)
);
